/* design/wildcard_byte_pattern_scanner_top_defines.svh */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH

// same-cycle implication
`define WBPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbps assertion failed");

// next-cycle implication
`define WBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbps assertion failed");

`endif

/* design/wbps_pkg.sv */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner package
// Widths, register indexes and the aligned pattern type shared by the block.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int MAX_PATTERN   = 32;
    localparam int BYTE_W        = 8;
    localparam int OFFSET_W      = 32;
    localparam int LEN_W         = 6;
    localparam int WORD_W        = 64;
    localparam int NUM_WORDS     = 4;
    localparam int MASK_W        = 32;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 6;
    localparam int REG_IDX_LSB   = 3;
    localparam int REG_IDX_W     = CFG_ADDR_W - REG_IDX_LSB;
    localparam int POS_W         = $clog2(MAX_PATTERN);
    localparam int BYTES_PER_WORD = WORD_W / BYTE_W;

    localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD0  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD1  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD2  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD3  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WILDCARD_MASK  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd5;

    localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

    typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_t;

    // pattern laid out against the window: entry j compares with window entry j
    typedef struct packed {
        window_t                 aligned_pattern;
        logic [MAX_PATTERN-1:0]  care;
        logic [LEN_W-1:0]        used_len;
    } cfg_t;

endpackage

/* design/wbps_in_if.sv */
// ----------------------------------------------------------------------------
// Scanner input channel
// Valid/ready channel carrying one region byte per item.
// ----------------------------------------------------------------------------
interface wbps_in_if;
    logic                       valid;
    logic                       ready;
    logic [wbps_pkg::BYTE_W-1:0] data_byte;
    logic                       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* design/wbps_out_if.sv */
// ----------------------------------------------------------------------------
// Scanner result channel
// Valid/ready channel carrying one scan result per item.
// ----------------------------------------------------------------------------
interface wbps_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [wbps_pkg::OFFSET_W-1:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

/* design/wbps_cfg.sv */
// ----------------------------------------------------------------------------
// Scanner configuration registers
// APB register file plus a registered, window-aligned copy of the pattern.
// ----------------------------------------------------------------------------
module wbps_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wbps_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [wbps_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output wbps_pkg::cfg_t                      cfg
);

    logic [wbps_pkg::NUM_WORDS-1:0][wbps_pkg::WORD_W-1:0] pattern_word_reg;
    logic [wbps_pkg::MASK_W-1:0]                          wildcard_mask_reg;
    logic [wbps_pkg::LEN_W-1:0]                           pattern_length_reg;
    wbps_pkg::cfg_t                                       cfg_reg;
    wbps_pkg::cfg_t                                       cfg_next;

    logic                               wr_en;
    logic [wbps_pkg::REG_IDX_W-1:0]     reg_idx;
    wbps_pkg::window_t                  pat_bytes;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[wbps_pkg::CFG_ADDR_W-1:wbps_pkg::REG_IDX_LSB];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_word_reg   <= '0;
            wildcard_mask_reg  <= '0;
            pattern_length_reg <= wbps_pkg::LEN_RESET;
            cfg_reg            <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (wr_en)
            begin
                case (reg_idx)
                    wbps_pkg::REG_PATTERN_WORD0:  pattern_word_reg[0] <= pwdata;
                    wbps_pkg::REG_PATTERN_WORD1:  pattern_word_reg[1] <= pwdata;
                    wbps_pkg::REG_PATTERN_WORD2:  pattern_word_reg[2] <= pwdata;
                    wbps_pkg::REG_PATTERN_WORD3:  pattern_word_reg[3] <= pwdata;
                    wbps_pkg::REG_WILDCARD_MASK:
                        wildcard_mask_reg <= pwdata[wbps_pkg::MASK_W-1:0];
                    wbps_pkg::REG_PATTERN_LENGTH:
                        pattern_length_reg <= pwdata[wbps_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (reg_idx)
            wbps_pkg::REG_PATTERN_WORD0:  prdata = pattern_word_reg[0];
            wbps_pkg::REG_PATTERN_WORD1:  prdata = pattern_word_reg[1];
            wbps_pkg::REG_PATTERN_WORD2:  prdata = pattern_word_reg[2];
            wbps_pkg::REG_PATTERN_WORD3:  prdata = pattern_word_reg[3];
            wbps_pkg::REG_WILDCARD_MASK:
                prdata = wbps_pkg::CFG_DATA_W'(wildcard_mask_reg);
            wbps_pkg::REG_PATTERN_LENGTH:
                prdata = wbps_pkg::CFG_DATA_W'(pattern_length_reg);
            default:                      prdata = '0;
        endcase
    end

    assign pat_bytes = pattern_word_reg;

    // clamp length, then lay pattern byte (len-1-j) against window entry j
    always_comb
    begin
        logic [wbps_pkg::LEN_W-1:0] len;
        logic [wbps_pkg::LEN_W-1:0] rel;
        if (pattern_length_reg == '0)
            len = wbps_pkg::LEN_W'(1);
        else if (pattern_length_reg > wbps_pkg::LEN_W'(wbps_pkg::MAX_PATTERN))
            len = wbps_pkg::LEN_W'(wbps_pkg::MAX_PATTERN);
        else
            len = pattern_length_reg;
        cfg_next.used_len = len;
        for (int j = 0; j < wbps_pkg::MAX_PATTERN; j++)
        begin
            rel = len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(j);
            if (wbps_pkg::LEN_W'(j) < len)
            begin
                cfg_next.aligned_pattern[j] = pat_bytes[rel[wbps_pkg::POS_W-1:0]];
                cfg_next.care[j] = !wildcard_mask_reg[rel[wbps_pkg::POS_W-1:0]];
            end
            else
            begin
                cfg_next.aligned_pattern[j] = '0;
                cfg_next.care[j] = 1'b0;
            end
        end
    end

endmodule

/* design/wbps_core.sv */
// ----------------------------------------------------------------------------
// Scanner core
// Input register, window shift and masked compare, result register.
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_scanner_top_defines.svh"

module wbps_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  wbps_pkg::cfg_t     cfg,
    wbps_in_if.sink            scan_in,
    wbps_out_if.source         scan_out
);

    logic                               in_valid_reg;
    logic                               in_valid_next;
    logic [wbps_pkg::BYTE_W-1:0]        in_data_reg;
    logic                               in_last_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic                               out_found_reg;
    logic [wbps_pkg::OFFSET_W-1:0]      out_offset_reg;
    wbps_pkg::window_t                  window_reg;
    wbps_pkg::window_t                  window_next;
    logic [wbps_pkg::OFFSET_W-1:0]      count_reg;
    logic [wbps_pkg::OFFSET_W-1:0]      count_next;
    logic                               reported_reg;
    logic                               reported_next;

    logic                               take_in;
    logic                               advance;
    wbps_pkg::window_t                  window_shift;
    logic [wbps_pkg::OFFSET_W-1:0]      count_inc;
    logic [wbps_pkg::MAX_PATTERN-1:0]   byte_ok;
    logic                               len_ok;
    logic                               match;
    logic                               res_valid;
    logic [wbps_pkg::OFFSET_W-1:0]      res_offset;

    assign advance        = in_valid_reg && (!out_valid_reg || scan_out.ready);
    assign scan_in.ready  = !in_valid_reg || advance;
    assign take_in        = scan_in.valid && scan_in.ready;

    assign scan_out.valid        = out_valid_reg;
    assign scan_out.found        = out_found_reg;
    assign scan_out.match_offset = out_offset_reg;

    always_comb
    begin
        window_shift[0] = in_data_reg;
        for (int j = 1; j < wbps_pkg::MAX_PATTERN; j++)
            window_shift[j] = window_reg[j-1];
    end

    always_comb
    begin
        for (int j = 0; j < wbps_pkg::MAX_PATTERN; j++)
            byte_ok[j] = !cfg.care[j] || (window_shift[j] == cfg.aligned_pattern[j]);
    end

    assign count_inc  = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign len_ok     = count_inc >= wbps_pkg::OFFSET_W'(cfg.used_len);
    assign match      = !reported_reg && len_ok && (&byte_ok);
    assign res_valid  = match || (in_last_reg && !reported_reg);
    assign res_offset = match ? count_inc - wbps_pkg::OFFSET_W'(cfg.used_len) : '0;

    always_comb
    begin
        if (take_in)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance && res_valid)
            out_valid_next = 1'b1;
        else if (scan_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        window_next   = window_reg;
        count_next    = count_reg;
        reported_next = reported_reg;
        if (advance)
        begin
            if (in_last_reg)
            begin
                window_next   = '0;
                count_next    = '0;
                reported_next = 1'b0;
            end
            else
            begin
                window_next   = window_shift;
                count_next    = count_inc;
                reported_next = reported_reg || match;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= '0;
            count_reg     <= '0;
            reported_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            window_reg    <= window_next;
            count_reg     <= count_next;
            reported_reg  <= reported_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_data_reg <= scan_in.data_byte;
            in_last_reg <= scan_in.last_byte;
        end
        if (advance && res_valid)
        begin
            out_found_reg  <= match;
            out_offset_reg <= res_offset;
        end
    end

    `WBPS_ASSERT_NEXT(a_region_clear, advance && in_last_reg, count_reg == '0 && !reported_reg)
    `WBPS_ASSERT_NEXT(a_match_sticky, advance && match && !in_last_reg, reported_reg)
    `WBPS_ASSERT_NEXT(a_result_loaded, advance && res_valid, out_valid_reg)
    `WBPS_ASSERT_SAME(a_miss_zero_offset, out_valid_reg && !out_found_reg, out_offset_reg == '0)

endmodule

/* design/wildcard_byte_pattern_scanner_top.sv */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner
// Finds the first occurrence of a masked byte pattern in a byte region.
// ----------------------------------------------------------------------------
// An accepted byte's result passes the input register, then the result register.
// Throughput: one byte per cycle; input stalls while a result waits unaccepted.
// Config reaches the core through the register file, then the aligned pattern register.
// Reset: rst_n async active low; config and control registers to reset values, window cleared.
module wildcard_byte_pattern_scanner_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wbps_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [wbps_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    wbps_in_if.sink                             scan_in,
    wbps_out_if.source                          scan_out
);

    wbps_pkg::cfg_t cfg;

    wbps_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wbps_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .scan_in  (scan_in),
        .scan_out (scan_out)
    );

endmodule

/* tb/wildcard_byte_pattern_scanner_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner testbench
// Feeds byte regions through the scan channel under varied flow control and
// register settings, predicts the first-match reports with a local model and
// checks every result in order.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_top_tb;
    import wbps_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_BEYOND_LIST = 3'd7;
    localparam logic [BYTE_W-1:0] QMARK   = 8'h3F;
    localparam logic [BYTE_W-1:0] SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

    localparam int NUM_PHASES      = 8;
    localparam int PRESSURE_PHASE  = 4;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 500000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } region_byte_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } scan_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    wbps_in_if  scan_in_bus ();
    wbps_out_if scan_out_bus ();

    wildcard_byte_pattern_scanner_top u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .scan_in  (scan_in_bus),
        .scan_out (scan_out_bus)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // register mirror
    logic [WORD_W-1:0] pat_words [NUM_WORDS] = '{default: '0};
    logic [MASK_W-1:0] wc_mask     = '0;
    logic [LEN_W-1:0]  pat_len_reg = LEN_RESET;

    // region state mirror
    logic [BYTE_W-1:0]   scan_window [MAX_PATTERN] = '{default: '0};
    logic [OFFSET_W-1:0] bytes_in_region = '0;
    logic                match_done = 1'b0;

    region_byte_t byte_queue [$];
    scan_result_t awaited_results [$];
    int bytes_queued   = 0;
    int bytes_accepted = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_armed   = 1'b0;
    logic hold_done;
    int   hold_count;

    function automatic logic [BYTE_W-1:0] pattern_byte_at(input int i);
        return pat_words[i / BYTES_PER_WORD][(i % BYTES_PER_WORD) * BYTE_W +: BYTE_W];
    endfunction

    function automatic int effective_length();
        int n;
        n = int'(pat_len_reg);
        if (n < 1)
            n = 1;
        if (n > MAX_PATTERN)
            n = MAX_PATTERN;
        return n;
    endfunction

    function automatic void advance_scan(input logic [BYTE_W-1:0] b, input logic last);
        int n;
        logic hit;
        scan_result_t r;
        n = effective_length();
        for (int i = MAX_PATTERN - 1; i > 0; i--)
            scan_window[i] = scan_window[i-1];
        scan_window[0] = b;
        if (bytes_in_region != '1)
            bytes_in_region++;
        hit = !match_done && (bytes_in_region >= OFFSET_W'(n));
        for (int i = 0; i < n; i++)
            if (!wc_mask[i] && scan_window[n-1-i] != pattern_byte_at(i))
                hit = 1'b0;
        if (hit)
        begin
            match_done = 1'b1;
            r.found    = 1'b1;
            r.offset   = bytes_in_region - OFFSET_W'(n);
            awaited_results.push_back(r);
        end
        else if (last && !match_done)
        begin
            r.found  = 1'b0;
            r.offset = '0;
            awaited_results.push_back(r);
        end
        if (last)
        begin
            scan_window     = '{default: '0};
            bytes_in_region = '0;
            match_done      = 1'b0;
        end
    endfunction

    function automatic void queue_byte(input logic [BYTE_W-1:0] data, input logic last);
        region_byte_t rb;
        rb.data = data;
        rb.last = last;
        byte_queue.push_back(rb);
        bytes_queued++;
    endfunction

    // filler leans on pattern bytes so near misses are common
    function automatic void queue_random_region(input int max_len);
        int n;
        int plen;
        int at;
        logic [BYTE_W-1:0] region_bytes [$];
        plen = effective_length();
        if (max_len > 0)
            n = $urandom_range(max_len, 1);
        else if ($urandom_range(99) < 10)
            n = $urandom_range(3 * plen + 20, 1);
        else
            n = $urandom_range(2 * plen + 6, 1);
        for (int i = 0; i < n; i++)
            if ($urandom_range(99) < 55)
                region_bytes.push_back(pattern_byte_at($urandom_range(plen - 1)));
            else
                region_bytes.push_back(BYTE_W'($urandom_range(255)));
        if (n >= plen && $urandom_range(99) < 60)
        begin
            at = $urandom_range(n - plen);
            for (int i = 0; i < plen; i++)
                if (!wc_mask[i])
                    region_bytes[at + i] = pattern_byte_at(i);
        end
        for (int i = 0; i < n; i++)
            queue_byte(region_bytes[i], i == n - 1);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {REG_IDX_LSB{1'b0}}};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PATTERN_WORD0:  pat_words[0] = val;
            REG_PATTERN_WORD1:  pat_words[1] = val;
            REG_PATTERN_WORD2:  pat_words[2] = val;
            REG_PATTERN_WORD3:  pat_words[3] = val;
            REG_WILDCARD_MASK:  wc_mask = val[MASK_W-1:0];
            REG_PATTERN_LENGTH: pat_len_reg = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // upper bits of the narrow registers carry junk
    task automatic load_config(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                               input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3,
                               input logic [MASK_W-1:0] mask, input logic [LEN_W-1:0] len);
        reg_write(REG_PATTERN_WORD0, w0);
        reg_write(REG_PATTERN_WORD1, w1);
        reg_write(REG_PATTERN_WORD2, w2);
        reg_write(REG_PATTERN_WORD3, w3);
        reg_write(REG_WILDCARD_MASK, {32'($urandom), mask});
        reg_write(REG_PATTERN_LENGTH, {32'($urandom), 26'($urandom), len});
    endtask

    task automatic drain_and_settle();
        while (bytes_accepted != bytes_queued || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        region_byte_t rb;
        if (!rst_n)
        begin
            scan_in_bus.valid     <= 1'b0;
            scan_in_bus.data_byte <= '0;
            scan_in_bus.last_byte <= 1'b0;
        end
        else
        begin
            if (scan_in_bus.valid && scan_in_bus.ready)
            begin
                advance_scan(scan_in_bus.data_byte, scan_in_bus.last_byte);
                bytes_accepted++;
            end
            if (!scan_in_bus.valid || scan_in_bus.ready)
            begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    rb = byte_queue.pop_front();
                    scan_in_bus.valid     <= 1'b1;
                    scan_in_bus.data_byte <= rb.data;
                    scan_in_bus.last_byte <= rb.last;
                end
                else
                begin
                    scan_in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count <= 0;
            hold_done  <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t want;
        if (!rst_n)
        begin
            scan_out_bus.ready <= 1'b0;
        end
        else
        begin
            if (scan_out_bus.valid && scan_out_bus.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result found=%0b offset=%0d",
                                              scan_out_bus.found, scan_out_bus.match_offset));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (scan_out_bus.found !== want.found)
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  scan_out_bus.found, want.found));
                    if (scan_out_bus.match_offset !== want.offset)
                        report_mismatch($sformatf("match_offset %0d, expected %0d",
                                                  scan_out_bus.match_offset, want.offset));
                end
            end
            scan_out_bus.ready <= !(hold_armed && !hold_done) &&
                                  ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("wildcard_byte_pattern_scanner_top_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [WORD_W-1:0] w [NUM_WORDS];
        logic [MASK_W-1:0] mask;
        logic [LEN_W-1:0]  len;
        int                start;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset pattern: a single zero byte
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        drain_and_settle();

        reg_write(REG_BEYOND_LIST, '1);
        load_config({40'd0, NEWLINE, QMARK, QMARK}, '0, '0, '0, '0, 6'd3);
        // restart after a partial match, short region, match on the last byte
        queue_byte(QMARK, 1'b0);
        queue_byte(QMARK, 1'b0);
        queue_byte(QMARK, 1'b0);
        queue_byte(NEWLINE, 1'b1);
        queue_byte(QMARK, 1'b0);
        queue_byte(QMARK, 1'b1);
        queue_byte(QMARK, 1'b0);
        queue_byte(QMARK, 1'b0);
        queue_byte(NEWLINE, 1'b1);
        drain_and_settle();

        reg_write(REG_WILDCARD_MASK, 64'h2);
        queue_byte(QMARK, 1'b0);
        queue_byte(SPACE, 1'b0);
        queue_byte(NEWLINE, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(NEWLINE, 1'b1);
        drain_and_settle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            for (int k = 0; k < NUM_WORDS; k++)
                w[k] = {$urandom, $urandom};
            mask = $urandom & $urandom & $urandom;
            case (ph)
                0: begin len = 6'd1;  mask = '0; end
                1: begin len = 6'd32; mask = '0; end
                2: begin len = 6'd32; mask = '1; end
                3: len = 6'd63;
                4: len = 6'd0;
                5: len = LEN_W'($urandom_range(8, 2));
                6: begin len = LEN_W'($urandom_range(31, 9)); mask = $urandom & $urandom; end
                default:
                begin
                    len = 6'd6;
                    for (int k = 0; k < MAX_PATTERN; k++)
                        case ($urandom_range(2))
                            0: w[k / BYTES_PER_WORD][(k % BYTES_PER_WORD) * BYTE_W +: BYTE_W] = QMARK;
                            1: w[k / BYTES_PER_WORD][(k % BYTES_PER_WORD) * BYTE_W +: BYTE_W] = SPACE;
                            default: w[k / BYTES_PER_WORD][(k % BYTES_PER_WORD) * BYTE_W +: BYTE_W] = NEWLINE;
                        endcase
                end
            endcase
            load_config(w[0], w[1], w[2], w[3], mask, len);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (ph == PRESSURE_PHASE)
                hold_armed = 1'b1;
            start = bytes_queued;
            while (bytes_queued - start < ITEMS_PER_PHASE)
                queue_random_region(ph == PRESSURE_PHASE ? 4 : 0);
            drain_and_settle();
        end

        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        if (mismatch_count == 0)
            $display("wildcard_byte_pattern_scanner_top_tb: done, clean");
        else
            $display("wildcard_byte_pattern_scanner_top_tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/wbps_pkg.sv
design/wbps_in_if.sv
design/wbps_out_if.sv
design/wbps_cfg.sv
design/wbps_core.sv
design/wildcard_byte_pattern_scanner_top.sv
tb/wildcard_byte_pattern_scanner_top_tb.sv
